// File: rtl/pet_tof_annihilation_point_assert.svh
`ifndef PET_TOF_ANNIHILATION_POINT_ASSERT_SVH
`define PET_TOF_ANNIHILATION_POINT_ASSERT_SVH
// Assertion helpers, sampled on the rising clock edge, off during reset.
`define PTA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define PTA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: rtl/pta_pkg.sv
package pta_pkg;
  localparam int unsigned TimeW = 48;
  localparam int unsigned PosW  = 32;
  localparam int unsigned OutW  = 48;
  localparam int unsigned InW   = 8 + 4 * TimeW + 4 * PosW;
  localparam int unsigned ResW  = 3 * OutW + 2;

  typedef enum logic [2:0] {
    CfgZVel   = 3'd0,
    CfgTofVel = 3'd1,
    CfgLimX   = 3'd2,
    CfgLimY   = 3'd3,
    CfgLimZ   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] z_velocity;
    logic [15:0] tof_velocity;
    logic [9:0]  limit_x;
    logic [9:0]  limit_y;
    logic [9:0]  limit_z;
  } cfg_t;

  // queue fill state seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [OutW-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] mx;
    mx = 64'sh0000_7FFF_FFFF_FFFF;
    if (v > mx) sat48 = mx[OutW-1:0];
    else if (v < -mx - 64'sd1) sat48 = {1'b1, {(OutW-1){1'b0}}};
    else sat48 = v[OutW-1:0];
  endfunction

  // sign * trunc(|a| * b / 2^9), saturated; |a| < 2^50 so product < 2^66
  function automatic logic signed [OutW-1:0] mul_q9(input logic signed [49:0] a,
                                                    input logic [15:0] b);
    logic [49:0] m;
    logic [65:0] p;
    logic [56:0] q;
    logic signed [63:0] r;
    m = a[49] ? 50'(-a) : 50'(a);
    p = 66'(m) * 66'(b);
    q = p[65:9];
    if (q > 57'(64'h1_0000_0000_0000)) q = 57'(64'h1_0000_0000_0000);
    r = 64'(q);
    mul_q9 = sat48(a[49] ? -r : r);
  endfunction
endpackage

// File: rtl/pet_tof_annihilation_point.sv
// Time-of-flight annihilation point for two-hit events. An event with a hit
// count other than two is dropped at the input. Accepted events pass an
// 8-entry queue to a serial back end: operand setup (SPre, SZ, SMid), a sum
// of squares, a 64-step square root and, per axis, a multiply plus a
// 128-step divide and a result write, then the limit check. The back end
// holds one event from the queue read to the result transfer; a stalled
// result holds it longer. Events are taken every cycle until the queue fills,
// then only as the back end frees entries. Configuration is written by index
// on the cfg port; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module pet_tof_annihilation_point import pta_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // hit_count, first_time_a, first_time_b, second_time_a, second_time_b,
  // first_pos_x, first_pos_y, second_pos_x, second_pos_y
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // point_x, point_y, point_z, inside_volume, zero_length, zero fill
  output logic [151:0]    m_axis_tdata
);
  `include "pet_tof_annihilation_point_assert.svh"
  logic f_valid, q_rd;
  logic [InW-1:0] f_data, q_data;
  q_stat_t q_stat;
  cfg_t cfg;
  logic [ResW-1:0] res;

  pta_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_data_i(s_axis_tdata),
    .q_stat_i(q_stat), .f_valid_o(f_valid), .f_data_o(f_data), .cfg_o(cfg)
  );
  pta_fifo #(.Depth(8)) u_fifo (
    .clk_i, .rst_ni, .wr_i(f_valid), .wdata_i(f_data), .rd_i(q_rd),
    .rdata_o(q_data), .stat_o(q_stat)
  );
  pta_back #(.FractionBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_empty_i(q_stat.empty), .q_data_i(q_data),
    .q_rd_o(q_rd), .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(res)
  );
  assign m_axis_tdata = {6'd0, res};

  `PTA_ASSERT(a_no_rd_empty, clk_i, rst_ni, !(q_rd && q_stat.empty))
  `PTA_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid)
  `PTA_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata))
endmodule

// File: rtl/pta_front.sv
// Front end: config registers, event filter and the input register.
module pta_front import pta_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic [InW-1:0] s_data_i,
  input  q_stat_t        q_stat_i,
  output logic           f_valid_o,
  output logic [InW-1:0] f_data_o,
  output cfg_t           cfg_o
);
  cfg_t cfg_q;
  logic v_q;
  logic [InW-1:0] d_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;
  // one slot in flight plus the queue: take input unless queue full
  assign s_ready_o = !q_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd2816, 16'd7680, 10'd100, 10'd100, 10'd50};
      v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgZVel:   cfg_q.z_velocity   <= cfg_data_i;
          CfgTofVel: cfg_q.tof_velocity <= cfg_data_i;
          CfgLimX:   cfg_q.limit_x      <= cfg_data_i[9:0];
          CfgLimY:   cfg_q.limit_y      <= cfg_data_i[9:0];
          CfgLimZ:   cfg_q.limit_z      <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      v_q <= s_valid_i && s_ready_o && s_data_i[7:0] == 8'd2;
    end
  end

  always_ff @(posedge clk_i) d_q <= s_data_i;

  assign f_valid_o = v_q;
  assign f_data_o  = d_q;
endmodule

// File: rtl/pta_fifo.sv
// Small queue between front and back ends.
module pta_fifo import pta_pkg::*; #(
  parameter int unsigned Depth = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  logic [InW-1:0] wdata_i,
  input  logic           rd_i,
  output logic [InW-1:0] rdata_o,
  output q_stat_t        stat_o
);
  localparam int unsigned AW = $clog2(Depth);
  logic [InW-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  // keep two free slots: one for the item in the front register
  assign stat_o.full  = cnt_q >= (AW+1)'(Depth - 2);
  assign stat_o.empty = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (wr_i) mem_q[wp_q] <= wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(rd_i);
    end
  end
endmodule

// File: rtl/pta_back.sv
// Back end: one event at a time through sqrt and three divides.
module pta_back import pta_pkg::*; #(
  parameter int unsigned FractionBits = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  logic           q_empty_i,
  input  logic [InW-1:0] q_data_i,
  output logic           q_rd_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [ResW-1:0] m_data_o
);
  typedef enum logic [3:0] {
    SIdle, SPre, SZ, SMid, SSq, SSqrt, SDiv, SLim, SOut
  } st_e;
  st_e st_q;
  logic signed [47:0] a1, b1, a2, b2;
  logic signed [31:0] x1, y1, x2, y2;
  logic signed [49:0] td1_q, td2_q, tm_q;
  logic signed [47:0] z1_q, z2_q, s_q;
  logic signed [49:0] dz_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [48:0] mx_q, my_q, mz_q;
  logic [127:0] sq_q;
  logic [67:0] rem_q;
  logic [63:0] root_q;
  logic [7:0] cnt_q;
  logic [1:0] ax_q;
  logic [127:0] num_q;
  logic [64:0] drem_q;
  logic [63:0] quo_q;
  logic signed [47:0] px_q, py_q, pz_q;
  logic zero_q, in_q;
  logic [InW-1:0] ev_q;

  assign {y2, x2, y1, x1, b2, a2, b1, a1} = ev_q[InW-1:8];

  // per-axis magnitude and sign for the squares and the offset division
  logic [47:0] dmag;
  logic dneg;
  logic [47:0] smag;
  always_comb begin
    case (ax_q)
      2'd0: begin dmag = 48'(dx_q[32] ? -dx_q : dx_q); dneg = dx_q[32]; end
      2'd1: begin dmag = 48'(dy_q[32] ? -dy_q : dy_q); dneg = dy_q[32]; end
      default: begin dmag = 48'(dz_q[49] ? -dz_q : dz_q); dneg = dz_q[49]; end
    endcase
    smag = s_q[47] ? 48'(-49'(s_q)) : 48'(s_q);
  end

  // 48x16 partial product, one 16-bit slice of the second operand per cycle
  logic [47:0] bsrc;
  logic [15:0] chunk;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  always_comb begin
    bsrc = (st_q == SSq) ? dmag : smag;
    case (cnt_q[1:0])
      2'd0: chunk = bsrc[15:0];
      2'd1: chunk = bsrc[31:16];
      default: chunk = bsrc[47:32];
    endcase
    pp = 64'(dmag) * 64'(chunk);
    case (cnt_q[1:0])
      2'd0: pp_sh = 128'(pp);
      2'd1: pp_sh = 128'(pp) << 16;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  // restoring square root, two radicand bits per step
  logic [67:0] srem;
  logic [67:0] strial;
  assign srem   = {rem_q[65:0], sq_q[127:126]};
  assign strial = {2'b00, root_q, 2'b01};

  logic [64:0] dtry;
  assign dtry = {drem_q[63:0], num_q[127]};

  function automatic logic in_lim(input logic signed [47:0] v, input logic [9:0] l);
    logic signed [63:0] lw;
    lw = 64'(l) <<< FractionBits;
    in_lim = 64'(v) > -lw && 64'(v) < lw;
  endfunction

  logic signed [63:0] sum;
  always_comb begin
    case (ax_q)
      2'd0: sum = 64'(mx_q >>> 1);
      2'd1: sum = 64'(my_q >>> 1);
      default: sum = 64'(mz_q >>> 1);
    endcase
    sum = sum + ((dneg != s_q[47]) ? -64'(quo_q) : 64'(quo_q));
  end

  assign q_rd_o = st_q == SIdle && !q_empty_i;
  assign m_valid_o = st_q == SOut;
  assign m_data_o = {zero_q, in_q, pz_q, py_q, px_q};

  always_ff @(posedge clk_i) begin
    if (q_rd_o) ev_q <= q_data_i;
    case (st_q)
      SPre: begin
        td1_q <= 50'(a1) - 50'(b1);
        td2_q <= 50'(a2) - 50'(b2);
        tm_q  <= (y1 > y2) ? (50'(a1)+50'(b1)-50'(a2)-50'(b2))
                           : (50'(a2)+50'(b2)-50'(a1)-50'(b1));
        dx_q <= 33'(x2) - 33'(x1);
        dy_q <= 33'(y2) - 33'(y1);
        mx_q <= 49'(x1) + 49'(x2);
        my_q <= 49'(y1) + 49'(y2);
      end
      SZ: begin
        z1_q <= mul_q9(td1_q, cfg_i.z_velocity);
        z2_q <= mul_q9(td2_q, cfg_i.z_velocity);
        s_q  <= mul_q9(tm_q, cfg_i.tof_velocity);
      end
      SMid: begin
        dz_q <= 50'(z2_q) - 50'(z1_q);
        mz_q <= 49'(z1_q) + 49'(z2_q);
        sq_q <= '0;
        rem_q <= '0;
        root_q <= '0;
      end
      SSq: sq_q <= sq_q + pp_sh;
      SSqrt: begin
        sq_q <= sq_q << 2;
        if (srem >= strial) begin
          rem_q <= srem - strial; root_q <= {root_q[62:0], 1'b1};
        end else begin
          rem_q <= srem; root_q <= {root_q[62:0], 1'b0};
        end
      end
      SDiv: begin
        if (cnt_q <= 8'd2) begin
          num_q <= ((cnt_q == 8'd0) ? '0 : num_q) + pp_sh;
          drem_q <= '0; quo_q <= '0;
        end else if (cnt_q <= 8'd130) begin
          num_q <= num_q << 1;
          if (dtry >= 65'(root_q)) begin
            drem_q <= dtry - 65'(root_q); quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            drem_q <= dtry; quo_q <= {quo_q[62:0], 1'b0};
          end
        end else begin
          case (ax_q)
            2'd0: px_q <= sat48(zero_q ? 64'(mx_q >>> 1) : sum);
            2'd1: py_q <= sat48(zero_q ? 64'(my_q >>> 1) : sum);
            default: pz_q <= sat48(zero_q ? 64'(mz_q >>> 1) : sum);
          endcase
        end
      end
      SLim: begin
        in_q <= !zero_q && in_lim(px_q, cfg_i.limit_x) && in_lim(py_q, cfg_i.limit_y)
                && in_lim(pz_q, cfg_i.limit_z);
      end
      default: ;
    endcase
    if (st_q == SDiv && cnt_q == 8'd0) zero_q <= root_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; ax_q <= '0;
    end else begin
      case (st_q)
        SIdle: if (!q_empty_i) st_q <= SPre;
        SPre: st_q <= SZ;
        SZ: st_q <= SMid;
        SMid: begin st_q <= SSq; cnt_q <= '0; ax_q <= '0; end
        SSq: begin
          if (cnt_q == 8'd2) begin
            cnt_q <= '0;
            if (ax_q == 2'd2) begin st_q <= SSqrt; ax_q <= '0; end
            else ax_q <= ax_q + 1'b1;
          end else cnt_q <= cnt_q + 1'b1;
        end
        SSqrt: begin
          if (cnt_q == 8'd63) begin st_q <= SDiv; cnt_q <= '0; ax_q <= '0; end
          else cnt_q <= cnt_q + 1'b1;
        end
        SDiv: begin
          if (cnt_q == 8'd131) begin
            cnt_q <= '0;
            if (ax_q == 2'd2) st_q <= SLim;
            else ax_q <= ax_q + 1'b1;
          end else cnt_q <= cnt_q + 1'b1;
        end
        SLim: st_q <= SOut;
        SOut: if (m_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

// File: verif/pet_tof_annihilation_point_tb.sv
`timescale 1ns / 1ps

module pet_tof_annihilation_point_tb;
  import pta_pkg::*;

  localparam int unsigned Frac       = 16;
  localparam int unsigned DrainWait  = 600;
  localparam longint      CycleLimit = 3_000_000;
  localparam logic [2:0]  CfgSpare   = 3'd7;  // not mapped, must be ignored
  localparam logic [7:0]  TwoHits    = 8'd2;

  typedef struct packed {
    logic [47:0] px;
    logic [47:0] py;
    logic [47:0] pz;
    logic        in_vol;
    logic        zero;
  } point_t;

  typedef struct {
    logic [7:0]  hits;
    logic [47:0] a1, b1, a2, b2;
    logic [31:0] x1, y1, x2, y2;
  } event_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [2:0]     cfg_index_i;
  logic [15:0]    cfg_data_i;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [InW-1:0] s_axis_tdata;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [151:0]   m_axis_tdata;

  cfg_t   cfg_model;
  point_t point_q[$];
  int     errors;
  longint cycles;
  bit     idle_en;
  int     stall_left;

  pet_tof_annihilation_point #(.FRACTION_BITS(Frac)) u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // sign * trunc(|a| * b / 2^9), saturated
  function automatic logic signed [63:0] scale_q9(input logic signed [63:0] a,
                                                  input logic [15:0] b);
    logic [127:0]       p;
    logic [127:0]       q;
    logic signed [63:0] r;
    logic [47:0]        t;
    p = 128'(magnitude(a)) * 128'(b);
    q = p >> 9;
    if (q > 128'(64'h1_0000_0000_0000)) q = 128'(64'h1_0000_0000_0000);
    r = q[63:0];
    t = clamp48(a < 0 ? -r : r);
    return $signed({{16{t[47]}}, t});
  endfunction

  function automatic logic signed [63:0] axis_shift(input logic signed [63:0] d,
                                                    input logic signed [63:0] s,
                                                    input logic [63:0] len);
    logic [127:0] q;
    q = (128'(magnitude(d)) * 128'(magnitude(s))) / 128'(len);
    return ((d < 0) != (s < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic bit in_range(input logic [47:0] v, input logic [9:0] lim);
    logic signed [63:0] l;
    logic signed [63:0] sv;
    l  = 64'(lim) << Frac;
    sv = $signed({{16{v[47]}}, v});
    return sv > -l && sv < l;
  endfunction

  function automatic point_t locate_point(input event_t e);
    logic signed [63:0] a1, b1, a2, b2, x1, y1, x2, y2, z1, z2, dx, dy, dz, m, s;
    logic signed [63:0] px, py, pz;
    logic [127:0]       sq, c;
    logic [63:0]        len;
    point_t             r;
    a1 = $signed({{16{e.a1[47]}}, e.a1}); b1 = $signed({{16{e.b1[47]}}, e.b1});
    a2 = $signed({{16{e.a2[47]}}, e.a2}); b2 = $signed({{16{e.b2[47]}}, e.b2});
    x1 = $signed({{32{e.x1[31]}}, e.x1}); y1 = $signed({{32{e.y1[31]}}, e.y1});
    x2 = $signed({{32{e.x2[31]}}, e.x2}); y2 = $signed({{32{e.y2[31]}}, e.y2});
    z1 = scale_q9(a1 - b1, cfg_model.z_velocity);
    z2 = scale_q9(a2 - b2, cfg_model.z_velocity);
    dx = x2 - x1; dy = y2 - y1; dz = z2 - z1;
    sq = 128'(magnitude(dx)) * 128'(magnitude(dx)) +
         128'(magnitude(dy)) * 128'(magnitude(dy)) +
         128'(magnitude(dz)) * 128'(magnitude(dz));
    len = '0;
    for (int b = 63; b >= 0; b--) begin
      c = 128'(len | (64'd1 << b));
      if (c * c <= sq) len = c[63:0];
    end
    m = (a1 + b1) - (a2 + b2);
    if (!(y1 > y2)) m = -m;
    s = scale_q9(m, cfg_model.tof_velocity);
    px = (x1 + x2) >>> 1;
    py = (y1 + y2) >>> 1;
    pz = (z1 + z2) >>> 1;
    r.zero = (len == 0);
    if (!r.zero) begin
      px += axis_shift(dx, s, len);
      py += axis_shift(dy, s, len);
      pz += axis_shift(dz, s, len);
    end
    r.px = clamp48(px); r.py = clamp48(py); r.pz = clamp48(pz);
    r.in_vol = !r.zero && in_range(r.px, cfg_model.limit_x) &&
               in_range(r.py, cfg_model.limit_y) && in_range(r.pz, cfg_model.limit_z);
    return r;
  endfunction

  function automatic logic [47:0] rand_time(input bit narrow);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (narrow) return 48'($signed(20'(v)));
    return v[47:0];
  endfunction

  function automatic logic [31:0] rand_pos(input bit narrow);
    if (narrow) return 32'($signed(24'($urandom)));
    return $urandom;
  endfunction

  function automatic event_t rand_event();
    event_t e;
    bit     narrow;
    narrow = $urandom_range(0, 4) != 0;
    e.hits = ($urandom_range(0, 3) != 0) ? TwoHits : 8'($urandom);
    e.a1 = rand_time(narrow); e.b1 = rand_time(narrow);
    e.a2 = rand_time(narrow); e.b2 = rand_time(narrow);
    e.x1 = rand_pos(narrow);  e.y1 = rand_pos(narrow);
    e.x2 = rand_pos(narrow);  e.y2 = rand_pos(narrow);
    if ($urandom_range(0, 30) == 0) begin
      e.x2 = e.x1; e.y2 = e.y1; e.a2 = e.a1; e.b2 = e.b1;
    end
    return e;
  endfunction

  task automatic send_event(input event_t e);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e.y2, e.x2, e.y1, e.x1, e.b2, e.a2, e.b1, e.a1, e.hits};
    do @(posedge clk_i); while (!s_axis_tready);
    if (e.hits == TwoHits) point_q.push_back(locate_point(e));
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgZVel:   cfg_model.z_velocity   = val;
      CfgTofVel: cfg_model.tof_velocity = val;
      CfgLimX:   cfg_model.limit_x      = val[9:0];
      CfgLimY:   cfg_model.limit_y      = val[9:0];
      CfgLimZ:   cfg_model.limit_z      = val[9:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] zv, input logic [15:0] tv,
                            input logic [9:0] lx, input logic [9:0] ly,
                            input logic [9:0] lz);
    wait_drain();
    write_reg(CfgZVel, zv);
    write_reg(CfgTofVel, tv);
    write_reg(CfgLimX, 16'(lx));
    write_reg(CfgLimY, 16'(ly));
    write_reg(CfgLimZ, 16'(lz));
  endtask

  task automatic test_dropped_counts();
    event_t     e;
    logic [7:0] counts [4];
    counts = '{8'd0, 8'd1, 8'd3, 8'd255};
    e = rand_event();
    foreach (counts[i]) begin
      e.hits = counts[i];
      send_event(e);
    end
  endtask

  task automatic test_directed();
    event_t e;
    // coincident hits: zero distance
    e = '{TwoHits, 48'd500, 48'd100, 48'd500, 48'd100,
          32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000};
    send_event(e);
    // near center, both y orders and equal y
    e = '{TwoHits, 48'd1000, 48'd200, 48'd300, 48'd900,
          32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 32'hFFE0_0000};
    send_event(e);
    e.y1 = 32'hFFE0_0000; e.y2 = 32'h0020_0000;
    send_event(e);
    e.y2 = e.y1;
    send_event(e);
    // time extremes drive z and shift into saturation
    e = '{TwoHits, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
          48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    send_event(e);
    e = '{TwoHits, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
          48'h8000_0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    send_event(e);
    e = '{TwoHits, 48'h0, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h0,
          32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0};
    send_event(e);
    e = '{TwoHits, 48'h0, 48'h0, 48'h0, 48'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_event(e);
    e = '{TwoHits, 48'h8000_0000_0000, 48'h0, 48'h0, 48'h0,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0};
    send_event(e);
  endtask

  task automatic test_random(input int n, input bit with_idle);
    idle_en = with_idle;
    for (int i = 0; i < n; i++) begin
      send_event(rand_event());
      if (i == n / 2) wait_drain();  // let the back end empty completely once
    end
  endtask

  task automatic test_spare_index();
    wait_drain();
    write_reg(CfgSpare, 16'hFFFF);
    test_random(20, 1'b1);
  endtask

  // result stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tdata[143:96],
              m_axis_tdata[144], m_axis_tdata[145]};
      if (point_q.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, got);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (got.px !== want.px) begin
          $display("%0t point_x expected %h actual %h", $time, want.px, got.px);
          errors++;
        end
        if (got.py !== want.py) begin
          $display("%0t point_y expected %h actual %h", $time, want.py, got.py);
          errors++;
        end
        if (got.pz !== want.pz) begin
          $display("%0t point_z expected %h actual %h", $time, want.pz, got.pz);
          errors++;
        end
        if (got.in_vol !== want.in_vol) begin
          $display("%0t inside_volume expected %b actual %b", $time, want.in_vol,
                   got.in_vol);
          errors++;
        end
        if (got.zero !== want.zero) begin
          $display("%0t zero_length expected %b actual %b", $time, want.zero,
                   got.zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[pet_tof_annihilation_point] ERROR");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    cycles        = 0;
    idle_en       = 1'b1;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgZVel;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_model     = '{16'd2816, 16'd7680, 10'd100, 10'd100, 10'd50};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_dropped_counts();
    test_directed();
    test_random(250, 1'b1);
    set_config(16'd0, 16'd0, 10'd0, 10'd0, 10'd0);
    test_directed();
    test_random(100, 1'b1);
    set_config(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 10'd1023);
    test_directed();
    test_random(250, 1'b1);
    set_config(16'h0100, 16'h0080, 10'd200, 10'd50, 10'd1023);
    test_random(250, 1'b1);
    test_spare_index();
    set_config(16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom),
               10'($urandom));
    test_random(250, 1'b1);
    set_config(16'd2816, 16'd7680, 10'd100, 10'd100, 10'd50);
    test_random(250, 1'b0);

    wait_drain();
    if (errors == 0) begin
      $display("[pet_tof_annihilation_point] OK");
    end else begin
      $display("[pet_tof_annihilation_point] ERROR");
    end
    $finish;
  end

endmodule
